// ===== rtl/adaptive_bezier_flattening_unit_assert.svh =====
// Assertion macros for the Bezier flattening unit.
// Included by the top level; relies on the clk and rst_n names in scope.
`ifndef ADAPTIVE_BEZIER_FLATTENING_UNIT_ASSERT_SVH
`define ADAPTIVE_BEZIER_FLATTENING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ABF_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ABF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ABF_ASSERT(label, cond)
`define ABF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/abf_pkg.sv =====
// Shared types and constants of the Bezier flattening unit.
// No dependencies; every module that uses it refers to it by scoped names.
package abf_pkg;

    localparam int COORD_W       = 22;
    localparam int MAX_LEVEL_DEF = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [2:0]  LEVEL_RESET = 3'd5;
    localparam logic [15:0] TOL_RESET   = 16'd64;

    // Configuration register indexes.
    localparam logic REG_MAX_LEVEL = 1'b0;
    localparam logic REG_FLAT_TOL  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    // Entries 0..7: p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y.
    typedef coord_t [7:0] seg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic start;
    } flat_req_t;

    typedef struct packed {
        logic done;
        logic flat;
    } flat_rsp_t;

endpackage

// ===== rtl/abf_queue.sv =====
// Short curve queue between the front and back ends.
// Depends on abf_pkg for the segment type and the depth.
module abf_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  abf_pkg::seg_t       push_data,
    input  logic                pop,
    output abf_pkg::seg_t       head,
    output abf_pkg::queue_stat_t stat
);

    localparam int QAW = (abf_pkg::QUEUE_DEPTH > 1) ? $clog2(abf_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(abf_pkg::QUEUE_DEPTH + 1);

    abf_pkg::seg_t    store_reg [abf_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    assign stat.full  = (count_reg == QCW'(abf_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(abf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(abf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/abf_front.sv =====
// Front end: takes one curve beat, widens it to Q16.6 and raises quadratics.
// Depends on abf_pkg; feeds abf_queue.
module abf_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [15:0]   start_x,
    input  logic signed [15:0]   start_y,
    input  logic signed [15:0]   ctrl1_x,
    input  logic signed [15:0]   ctrl1_y,
    input  logic signed [15:0]   ctrl2_x,
    input  logic signed [15:0]   ctrl2_y,
    input  logic signed [15:0]   end_x,
    input  logic signed [15:0]   end_y,
    input  logic                 is_quadratic,
    output logic                 push,
    output abf_pkg::seg_t        push_data,
    input  abf_pkg::queue_stat_t q_stat
);

    // floor(n / 3) = (n * DIV3_K) >> DIV3_SHIFT for every n below 2^23.
    localparam int          DIV3_SHIFT = 25;
    localparam logic [23:0] DIV3_K     = 24'd11184811;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_ABS  = 5'b00010,
        F_MUL  = 5'b00100,
        F_ADD  = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic [1:0]         k_reg, k_next;

    abf_pkg::seg_t      seg_reg;
    logic signed [15:0] sx_reg, sy_reg, qx_reg, qy_reg, ex_reg, ey_reg;
    logic [22:0]        n_reg;
    logic               neg_reg;
    logic [21:0]        quot_reg;

    logic               accept;
    logic signed [15:0] base16;
    logic signed [15:0] q16;
    logic signed [16:0] dq;
    logic [16:0]        adq;
    logic [22:0]        n_next;
    logic [46:0]        prod;
    logic signed [22:0] base_w;
    logic signed [22:0] offs;
    logic signed [22:0] ctl;

    assign in_stall  = (state_reg != F_IDLE);
    assign accept    = in_valid && (state_reg == F_IDLE);
    assign push_data = seg_reg;

    always_comb
    begin
        case (k_reg)
            2'd0:    base16 = sx_reg;
            2'd1:    base16 = sy_reg;
            2'd2:    base16 = ex_reg;
            default: base16 = ey_reg;
        endcase
        q16    = k_reg[0] ? qy_reg : qx_reg;
        dq     = {q16[15], q16} - {base16[15], base16};
        adq    = dq[16] ? 17'(-dq) : 17'(dq);
        // |2 * dq * 64| + 1; the low bits of the scaled value are zero.
        n_next = {adq[15:0], 7'b0000001};
        prod   = 47'(n_reg) * 47'(DIV3_K);
        base_w = {base16[15], base16, 6'b0};
        offs   = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
        ctl    = base_w + offs;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                k_next = 2'd0;
                if (in_valid)
                begin
                    state_next = is_quadratic ? F_ABS : F_PUSH;
                end
            end
            F_ABS:  state_next = F_MUL;
            F_MUL:  state_next = F_ADD;
            F_ADD:
            begin
                k_next     = k_reg + 1'b1;
                state_next = (k_reg == 2'd3) ? F_PUSH : F_ABS;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seg_reg[0] <= {start_x, 6'b0};
            seg_reg[1] <= {start_y, 6'b0};
            seg_reg[2] <= {ctrl1_x, 6'b0};
            seg_reg[3] <= {ctrl1_y, 6'b0};
            seg_reg[4] <= {ctrl2_x, 6'b0};
            seg_reg[5] <= {ctrl2_y, 6'b0};
            seg_reg[6] <= {end_x, 6'b0};
            seg_reg[7] <= {end_y, 6'b0};
            sx_reg     <= start_x;
            sy_reg     <= start_y;
            qx_reg     <= ctrl1_x;
            qy_reg     <= ctrl1_y;
            ex_reg     <= end_x;
            ey_reg     <= end_y;
        end
        if (state_reg == F_ABS)
        begin
            n_reg   <= n_next;
            neg_reg <= dq[16];
        end
        if (state_reg == F_MUL)
        begin
            quot_reg <= prod[DIV3_SHIFT+21:DIV3_SHIFT];
        end
        if (state_reg == F_ADD)
        begin
            seg_reg[{1'b0, k_reg} + 3'd2] <= ctl[21:0];
        end
    end

endmodule

// ===== rtl/abf_flat.sv =====
// Flatness test: exact cross products and squares on one shared multiplier.
// Depends on abf_pkg; driven by abf_back.
module abf_flat
(
    input  logic               clk,
    input  logic               rst_n,
    input  abf_pkg::flat_req_t req,
    input  abf_pkg::seg_t      seg,
    input  logic [15:0]        tol,
    output abf_pkg::flat_rsp_t rsp
);

    localparam logic [3:0] ST_AXDY = 4'd0;
    localparam logic [3:0] ST_AYDX = 4'd1;
    localparam logic [3:0] ST_BXDY = 4'd2;
    localparam logic [3:0] ST_BYDX = 4'd3;
    localparam logic [3:0] ST_DXDX = 4'd4;
    localparam logic [3:0] ST_DYDY = 4'd5;
    localparam logic [3:0] ST_SLSL = 4'd6;
    localparam logic [3:0] ST_SHSL = 4'd7;
    localparam logic [3:0] ST_SHSH = 4'd8;
    localparam logic [3:0] ST_TLO  = 4'd9;
    localparam logic [3:0] ST_THI  = 4'd10;

    logic               run_reg, pvalid_reg, cmp_reg, done_reg, flat_reg;
    logic [3:0]         step_reg, pstep_reg;
    logic signed [22:0] dx_reg, dy_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [49:0] prod_reg;
    logic signed [47:0] acc1_reg, acc2_reg;
    logic [46:0]        acc3_reg;
    logic [47:0]        sum_reg;
    logic [95:0]        l_reg;
    logic [62:0]        r_reg;

    logic signed [24:0] op_a, op_b;
    logic [47:0]        abs1, abs2;

    assign rsp.done = done_reg;
    assign rsp.flat = flat_reg;

    always_comb
    begin
        case (step_reg)
            ST_AXDY: begin op_a = 25'(ax_reg); op_b = 25'(dy_reg); end
            ST_AYDX: begin op_a = 25'(ay_reg); op_b = 25'(dx_reg); end
            ST_BXDY: begin op_a = 25'(bx_reg); op_b = 25'(dy_reg); end
            ST_BYDX: begin op_a = 25'(by_reg); op_b = 25'(dx_reg); end
            ST_DXDX: begin op_a = 25'(dx_reg); op_b = 25'(dx_reg); end
            ST_DYDY: begin op_a = 25'(dy_reg); op_b = 25'(dy_reg); end
            ST_SLSL: begin op_a = {1'b0, sum_reg[23:0]};  op_b = {1'b0, sum_reg[23:0]}; end
            ST_SHSL: begin op_a = {1'b0, sum_reg[47:24]}; op_b = {1'b0, sum_reg[23:0]}; end
            ST_SHSH: begin op_a = {1'b0, sum_reg[47:24]}; op_b = {1'b0, sum_reg[47:24]}; end
            ST_TLO:  begin op_a = {9'b0, tol}; op_b = {1'b0, acc3_reg[23:0]}; end
            default: begin op_a = {9'b0, tol}; op_b = {2'b0, acc3_reg[46:24]}; end
        endcase
        abs1 = acc1_reg[47] ? 48'(-acc1_reg) : 48'(acc1_reg);
        abs2 = acc2_reg[47] ? 48'(-acc2_reg) : 48'(acc2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            step_reg   <= ST_AXDY;
            pvalid_reg <= 1'b0;
            pstep_reg  <= ST_AXDY;
            cmp_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                run_reg  <= 1'b1;
                step_reg <= ST_AXDY;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == ST_THI)
                begin
                    run_reg <= 1'b0;
                end
            end
            pvalid_reg <= run_reg;
            pstep_reg  <= step_reg;
            cmp_reg    <= pvalid_reg && (pstep_reg == ST_THI);
            done_reg   <= cmp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dx_reg <= {seg[6][21], seg[6]} - {seg[0][21], seg[0]};
            dy_reg <= {seg[7][21], seg[7]} - {seg[1][21], seg[1]};
            ax_reg <= {seg[2][21], seg[2]} - {seg[6][21], seg[6]};
            ay_reg <= {seg[3][21], seg[3]} - {seg[7][21], seg[7]};
            bx_reg <= {seg[4][21], seg[4]} - {seg[6][21], seg[6]};
            by_reg <= {seg[5][21], seg[5]} - {seg[7][21], seg[7]};
        end
        prod_reg <= op_a * op_b;
        if (pvalid_reg)
        begin
            case (pstep_reg)
                ST_AXDY: acc1_reg <= prod_reg[47:0];
                ST_AYDX: acc1_reg <= acc1_reg - prod_reg[47:0];
                ST_BXDY: acc2_reg <= prod_reg[47:0];
                ST_BYDX: acc2_reg <= acc2_reg - prod_reg[47:0];
                ST_DXDX:
                begin
                    acc3_reg <= prod_reg[46:0];
                    // Both cross products are complete by now.
                    sum_reg  <= abs1 + abs2;
                end
                ST_DYDY: acc3_reg <= acc3_reg + prod_reg[46:0];
                ST_SLSL: l_reg <= {48'b0, prod_reg[47:0]};
                ST_SHSL: l_reg <= l_reg + {23'b0, prod_reg[47:0], 25'b0};
                ST_SHSH: l_reg <= l_reg + {prod_reg[47:0], 48'b0};
                ST_TLO:  r_reg <= {15'b0, prod_reg[47:0]};
                default: r_reg <= r_reg + {prod_reg[38:0], 24'b0};
            endcase
        end
        if (cmp_reg)
        begin
            flat_reg <= (l_reg <= {21'b0, r_reg, 12'b0});
        end
    end

endmodule

// ===== rtl/abf_back.sv =====
// Back end: depth-first de Casteljau subdivision with a stack of right halves.
// Depends on abf_pkg; uses abf_flat for the test and drives the point channel.
module abf_back
#(
    parameter int  MAX_LEVEL = abf_pkg::MAX_LEVEL_DEF,
    localparam int SPW       = $clog2(MAX_LEVEL + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SPW-1:0]       limit,
    input  abf_pkg::seg_t        q_head,
    input  abf_pkg::queue_stat_t q_stat,
    output logic                 q_pop,
    output abf_pkg::flat_req_t   flat_req,
    input  abf_pkg::flat_rsp_t   flat_rsp,
    output abf_pkg::seg_t        seg,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [21:0]   point_x,
    output logic signed [21:0]   point_y,
    output logic                 last_point
);

    localparam int AW = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_CHECK = 7'b0000010,
        B_WAIT  = 7'b0000100,
        B_SPLIT = 7'b0001000,
        B_EMIT  = 7'b0010000,
        B_POP   = 7'b0100000,
        B_LOAD  = 7'b1000000
    } bstate_t;

    typedef struct packed {
        abf_pkg::seg_t  seg;
        logic [SPW-1:0] lvl;
    } ent_t;

    bstate_t        state_reg, state_next;
    logic [SPW-1:0] lvl_reg, sp_reg;
    logic           out_valid_reg;
    abf_pkg::seg_t  seg_reg;
    ent_t           stack_mem [MAX_LEVEL];
    ent_t           rd_q;

    abf_pkg::seg_t  left, right;
    logic [SPW-1:0] sp_m1;
    logic           slot_free;
    logic           emit;

    function automatic abf_pkg::coord_t mid(input abf_pkg::coord_t a, input abf_pkg::coord_t b);
        logic signed [22:0] s;
        s = {a[21], a} + {b[21], b};
        return s[22:1];
    endfunction

    assign seg       = seg_reg;
    assign out_valid = out_valid_reg;
    assign sp_m1     = sp_reg - 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == B_EMIT) && slot_free;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            abf_pkg::coord_t p12, p23, p34, p123, p234, p1234;
            p12   = mid(seg_reg[k], seg_reg[2+k]);
            p23   = mid(seg_reg[2+k], seg_reg[4+k]);
            p34   = mid(seg_reg[4+k], seg_reg[6+k]);
            p123  = mid(p12, p23);
            p234  = mid(p23, p34);
            p1234 = mid(p123, p234);
            left[k]    = seg_reg[k];
            left[2+k]  = p12;
            left[4+k]  = p123;
            left[6+k]  = p1234;
            right[k]   = p1234;
            right[2+k] = p234;
            right[4+k] = p34;
            right[6+k] = seg_reg[6+k];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        q_pop          = 1'b0;
        flat_req.start = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (lvl_reg >= limit)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    flat_req.start = 1'b1;
                    state_next     = B_WAIT;
                end
            end
            B_WAIT:
            begin
                if (flat_rsp.done)
                begin
                    state_next = flat_rsp.flat ? B_EMIT : B_SPLIT;
                end
            end
            B_SPLIT: state_next = B_CHECK;
            B_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = (sp_reg == '0) ? B_IDLE : B_POP;
                end
            end
            B_POP:   state_next = B_LOAD;
            B_LOAD:  state_next = B_CHECK;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            lvl_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE)
            begin
                lvl_reg <= '0;
                sp_reg  <= '0;
            end
            else if (state_reg == B_SPLIT)
            begin
                lvl_reg <= lvl_reg + 1'b1;
                sp_reg  <= sp_reg + 1'b1;
            end
            else if (state_reg == B_LOAD)
            begin
                lvl_reg <= rd_q.lvl;
                sp_reg  <= sp_m1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            seg_reg <= q_head;
        end
        else if (state_reg == B_SPLIT)
        begin
            seg_reg <= left;
        end
        else if (state_reg == B_LOAD)
        begin
            seg_reg <= rd_q.seg;
        end
        if (emit)
        begin
            point_x    <= seg_reg[6];
            point_y    <= seg_reg[7];
            last_point <= (sp_reg == '0);
        end
    end

    // Right halves wait here until the left half is finished.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_SPLIT)
        begin
            stack_mem[sp_reg[AW-1:0]] <= '{seg: right, lvl: lvl_reg + 1'b1};
        end
        if (state_reg == B_POP)
        begin
            rd_q <= stack_mem[sp_m1[AW-1:0]];
        end
    end

endmodule

// ===== rtl/adaptive_bezier_flattening_unit.sv =====
// Bezier flattening unit: a curve beat in, a run of Q16.6 polyline point beats out.
// Each flatness test runs on the single shared 25x25 multiplier. The front end takes
// longer for a quadratic than for a cubic, and runs ahead by two curves.
// Reset is asynchronous: max_level 5, flatness_tol 64, queue and stack empty.
`include "adaptive_bezier_flattening_unit_assert.svh"

module adaptive_bezier_flattening_unit
#(
    parameter int MAX_LEVEL = abf_pkg::MAX_LEVEL_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  start_x,
    input  logic signed [15:0]  start_y,
    input  logic signed [15:0]  ctrl1_x,
    input  logic signed [15:0]  ctrl1_y,
    input  logic signed [15:0]  ctrl2_x,
    input  logic signed [15:0]  ctrl2_y,
    input  logic signed [15:0]  end_x,
    input  logic signed [15:0]  end_y,
    input  logic                is_quadratic,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [21:0]  point_x,
    output logic signed [21:0]  point_y,
    output logic                last_point
);

    localparam int SPW = $clog2(MAX_LEVEL + 1);

    logic [2:0]           max_level_reg;
    logic [15:0]          tol_reg;
    logic [SPW-1:0]       limit;

    logic                 q_push, q_pop;
    abf_pkg::seg_t        q_push_data, q_head, cur_seg;
    abf_pkg::queue_stat_t q_stat;
    abf_pkg::flat_req_t   flat_req;
    abf_pkg::flat_rsp_t   flat_rsp;

    assign limit = (max_level_reg > 3'(MAX_LEVEL)) ? SPW'(MAX_LEVEL) : max_level_reg[SPW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg <= abf_pkg::LEVEL_RESET;
            tol_reg       <= abf_pkg::TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                abf_pkg::REG_MAX_LEVEL: max_level_reg <= cfg_data[2:0];
                abf_pkg::REG_FLAT_TOL:  tol_reg       <= cfg_data;
                default:                tol_reg       <= tol_reg;
            endcase
        end
    end

    abf_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_x      (start_x),
        .start_y      (start_y),
        .ctrl1_x      (ctrl1_x),
        .ctrl1_y      (ctrl1_y),
        .ctrl2_x      (ctrl2_x),
        .ctrl2_y      (ctrl2_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .is_quadratic (is_quadratic),
        .push         (q_push),
        .push_data    (q_push_data),
        .q_stat       (q_stat)
    );

    abf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    abf_flat u_flat
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (flat_req),
        .seg   (cur_seg),
        .tol   (tol_reg),
        .rsp   (flat_rsp)
    );

    abf_back #(.MAX_LEVEL(MAX_LEVEL)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit),
        .q_head     (q_head),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .flat_req   (flat_req),
        .flat_rsp   (flat_rsp),
        .seg        (cur_seg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

    `ABF_ASSERT(a_no_push_when_full, !(q_push && q_stat.full))
    `ABF_ASSERT(a_no_pop_when_empty, !(q_pop && q_stat.empty))
    `ABF_ASSERT_NEXT(a_flat_not_instant, flat_req.start, !flat_rsp.done)

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the adaptive Bezier flattening unit (top: testbench).
// It needs abf_pkg and adaptive_bezier_flattening_unit. Each curve is predicted in-line,
// and every polyline point beat is checked against the queue of expected points.
module testbench;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [7:0][15:0] pt;     // sx, sy, c1x, c1y, c2x, c2y, ex, ey
        logic             quad;
    } curve_t;

    typedef struct packed {
        logic [21:0] x;
        logic [21:0] y;
        logic        last;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic signed [15:0] start_x, start_y, ctrl1_x, ctrl1_y;
    logic signed [15:0] ctrl2_x, ctrl2_y, end_x, end_y;
    logic        is_quadratic;
    logic        out_valid;
    logic        out_stall;
    logic signed [21:0] point_x, point_y;
    logic        last_point;

    point_t      expected_points[$];
    int unsigned mismatches;
    int unsigned curves_sent;
    int unsigned points_seen;
    int unsigned idle_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Own copy of the configuration.
    logic [2:0]  level_limit;
    logic [15:0] tolerance;

    adaptive_bezier_flattening_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .ctrl1_x(ctrl1_x), .ctrl1_y(ctrl1_y),
        .ctrl2_x(ctrl2_x), .ctrl2_y(ctrl2_y), .end_x(end_x), .end_y(end_y),
        .is_quadratic(is_quadratic),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_x(point_x), .point_y(point_y), .last_point(last_point)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint halve(longint s);
        return s >>> 1;
    endfunction

    function automatic longint third_rounded(longint v);
        if (v >= 0)
            return (v + 1) / 3;
        return -((-v + 1) / 3);
    endfunction

    function automatic bit segment_flat(longint s[8]);
        longint dx, dy, ax, ay, bx, by, c2, c3;
        logic [127:0] total, lhs, rhs;
        dx = s[6] - s[0];
        dy = s[7] - s[1];
        ax = s[2] - s[6];
        ay = s[3] - s[7];
        bx = s[4] - s[6];
        by = s[5] - s[7];
        c2 = ax * dy - ay * dx;
        c3 = bx * dy - by * dx;
        if (c2 < 0)
            c2 = -c2;
        if (c3 < 0)
            c3 = -c3;
        total = 128'(c2) + 128'(c3);
        lhs = total * total;
        rhs = (128'(tolerance) * 128'(dx * dx + dy * dy)) << 12;
        return lhs <= rhs;
    endfunction

    // Flattens one curve and queues its points in emission order.
    task automatic flatten_curve(input curve_t cv);
        longint seg[8];
        longint right[8];
        longint stack_seg[6][8];
        int     stack_lvl[6];
        int     depth, lvl, limit, n, i, k;
        longint qx, qy, p12, p23, p34, p123, p234, p1234;
        point_t pt;
        limit = (level_limit > 5) ? 5 : int'(level_limit);
        // The packed field holds the start x in its top slot.
        for (i = 0; i < 8; i++)
            seg[i] = longint'($signed(cv.pt[7 - i])) * 64;
        if (cv.quad)
        begin
            qx = seg[2];
            qy = seg[3];
            seg[2] = seg[0] + third_rounded((qx - seg[0]) * 2);
            seg[3] = seg[1] + third_rounded((qy - seg[1]) * 2);
            seg[4] = seg[6] + third_rounded((qx - seg[6]) * 2);
            seg[5] = seg[7] + third_rounded((qy - seg[7]) * 2);
        end
        depth = 0;
        lvl = 0;
        n = 0;
        forever
        begin
            if (lvl >= limit || segment_flat(seg))
            begin
                n++;
                pt.x = seg[6][21:0];
                pt.y = seg[7][21:0];
                pt.last = (depth == 0 || n >= 64);
                expected_points.insert(expected_points.size(), pt);
                if (pt.last)
                    break;
                depth--;
                seg = stack_seg[depth];
                lvl = stack_lvl[depth];
            end
            else
            begin
                for (k = 0; k < 2; k++)
                begin
                    p12 = halve(seg[k] + seg[2 + k]);
                    p23 = halve(seg[2 + k] + seg[4 + k]);
                    p34 = halve(seg[4 + k] + seg[6 + k]);
                    p123 = halve(p12 + p23);
                    p234 = halve(p23 + p34);
                    p1234 = halve(p123 + p234);
                    right[k] = p1234;
                    right[2 + k] = p234;
                    right[4 + k] = p34;
                    right[6 + k] = seg[6 + k];
                    seg[2 + k] = p12;
                    seg[4 + k] = p123;
                    seg[6 + k] = p1234;
                end
                lvl++;
                stack_seg[depth] = right;
                stack_lvl[depth] = lvl;
                depth++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [21:0] got,
                                   input logic [21:0] want);
        $display("mismatch on %s: got %0h, expected %0h (point %0d)",
                 what, got, want, points_seen);
        mismatches++;
    endtask

    // Sends one curve beat; called and returns at a falling edge.
    task automatic send_curve(input curve_t cv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y} = cv.pt;
        is_quadratic = cv.quad;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        flatten_curve(cv);
        curves_sent++;
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        in_valid = 1'b0;
        wait (expected_points.size() == 0);
        @(negedge clk);
    endtask

    task automatic write_register(input logic index, input logic [15:0] value);
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        if (index == abf_pkg::REG_MAX_LEVEL)
            level_limit = value[2:0];
        else
            tolerance = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic curve_t make_curve(input logic signed [15:0] sx, sy, c1x, c1y,
                                          c2x, c2y, ex, ey, input logic quad);
        curve_t cv;
        cv.pt = {sx, sy, c1x, c1y, c2x, c2y, ex, ey};
        cv.quad = quad;
        return cv;
    endfunction

    function automatic curve_t random_curve();
        curve_t cv;
        int i, span;
        // Mostly curves of moderate size so flatness decides; some span the full range.
        span = ($urandom_range(3) == 0) ? 32768 : (1 << $urandom_range(14, 4));
        for (i = 0; i < 8; i++)
            if (span == 32768)
                cv.pt[i] = 16'($urandom);
            else
                cv.pt[i] = 16'($urandom_range(2 * span - 1) - span);
        cv.quad = 1'($urandom_range(1));
        return cv;
    endfunction

    task automatic test_directed_shapes();
        send_curve(make_curve(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                              16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0));
        send_curve(make_curve(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                              16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1));
        send_curve(make_curve(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                              16'sh1234, 16'sh4321, 16'sh8000, 16'sh8000, 1'b1));
        // Degenerate chord: start and end coincide.
        send_curve(make_curve(100, 100, 900, -700, -500, 300, 100, 100, 1'b0));
        // A straight line, then one with odd coordinates to exercise floor rounding.
        send_curve(make_curve(0, 0, 10, 10, 20, 20, 30, 30, 1'b0));
        send_curve(make_curve(-3, 5, 17, -9, -1, 33, 7, -1, 1'b0));
        send_curve(make_curve(-1000, 0, 0, 2000, 0, 0, 1000, 0, 1'b1));
        send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_curve(make_curve(-1, -1, -1, -1, -1, -1, -1, -1, 1'b0));
    endtask

    task automatic test_register_extremes();
        // Level zero gives one point per curve.
        write_register(abf_pkg::REG_MAX_LEVEL, 16'd0);
        send_curve(make_curve(0, 0, 3000, 3000, -3000, 3000, 500, 0, 1'b0));
        send_curve(make_curve(0, 0, 3000, 3000, -3000, 3000, 500, 0, 1'b1));
        // Zero tolerance only accepts exactly straight segments.
        write_register(abf_pkg::REG_MAX_LEVEL, 16'd3);
        write_register(abf_pkg::REG_FLAT_TOL, 16'd0);
        send_curve(make_curve(0, 0, 16, 16, 32, 32, 48, 48, 1'b0));
        send_curve(make_curve(0, 0, 16, 20, 32, 32, 48, 48, 1'b0));
        write_register(abf_pkg::REG_FLAT_TOL, 16'hffff);
        send_curve(make_curve(0, 0, 4000, 9000, -9000, 400, 800, 0, 1'b0));
        // Levels above the limit behave as the limit.
        write_register(abf_pkg::REG_FLAT_TOL, 16'd0);
        write_register(abf_pkg::REG_MAX_LEVEL, 16'd7);
        send_curve(make_curve(-20000, 0, -5000, 30000, 5000, -30000, 20000, 0, 1'b0));
        write_register(abf_pkg::REG_MAX_LEVEL, 16'd6);
        send_curve(make_curve(-20000, 100, 0, 30000, 0, 0, 20000, 0, 1'b1));
        write_register(abf_pkg::REG_MAX_LEVEL, 16'd5);
        send_curve(make_curve(16'sh8000, 0, 16'sh7fff, 16'sh7fff, 16'sh8000,
                              16'sh8000, 16'sh7fff, 0, 1'b0));
    endtask

    task automatic test_random_curves(input int count, input int send_pct,
                                      input int recv_pct);
        int i;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_register(abf_pkg::REG_MAX_LEVEL, 16'($urandom_range(7)));
        write_register(abf_pkg::REG_FLAT_TOL, 16'($urandom_range(2048)));
        for (i = 0; i < count; i++)
        begin
            send_curve(random_curve());
            // The sender holds back once until all points of the previous curves are in.
            if (i == count / 2)
                wait_until_drained();
        end
    endtask

    // Receiver stall, changed at the falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Checks each point beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            points_seen++;
            if (expected_points.size() == 0)
            begin
                report_mismatch("point_x with no point expected", point_x, 22'd0);
            end
            else
            begin
                if (point_x !== expected_points[0].x)
                    report_mismatch("point_x", point_x, expected_points[0].x);
                if (point_y !== expected_points[0].y)
                    report_mismatch("point_y", point_y, expected_points[0].y);
                if (last_point !== expected_points[0].last)
                    report_mismatch("last_point", 22'(last_point),
                                    22'(expected_points[0].last));
                void'(expected_points.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d points outstanding",
                     expected_points.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = abf_pkg::REG_MAX_LEVEL;
        cfg_data = '0;
        in_valid = 1'b0;
        {start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y} = '0;
        is_quadratic = 1'b0;
        out_stall = 1'b0;
        mismatches = 0;
        curves_sent = 0;
        points_seen = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        level_limit = abf_pkg::LEVEL_RESET;
        tolerance = abf_pkg::TOL_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_shapes();
        test_register_extremes();
        test_random_curves(115, 33, 61);
        test_random_curves(115, 61, 33);
        test_random_curves(120, 0, 0);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Flattened %0d curves into %0d points over several level and tolerance settings.",
                 curves_sent, points_seen);
        $display("%0d mismatches found.", mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/abf_pkg.sv
rtl/abf_queue.sv
rtl/abf_front.sv
rtl/abf_flat.sv
rtl/abf_back.sv
rtl/adaptive_bezier_flattening_unit.sv
bench/testbench.sv
